// File: rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg: shared types, constants and round functions
// Holds the command and status records between the SHA-1 controller and
// datapath, the initial chaining values and the per-round F and K selection.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned WordW      = 32;
    localparam int unsigned ChainN     = 5;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned FillW      = 6;
    localparam int unsigned RoundW     = 7;
    localparam int unsigned IdxW       = 3;

    typedef logic [WordW-1:0]  t_word;
    typedef logic [7:0]        t_byte;
    typedef logic [RoundW-1:0] t_round;
    typedef logic [IdxW-1:0]   t_idx;
    typedef logic [FillW-1:0]  t_fill;

    localparam t_round LastRound = t_round'(79);
    localparam t_idx   LastWord  = t_idx'(4);
    localparam t_fill  LenFill   = t_fill'(56);
    localparam t_fill  FullFill  = t_fill'(63);
    localparam t_byte  PadMark   = 8'h80;

    localparam t_word ChainInit [ChainN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO
    } t_byte_src;

    typedef struct packed {
        logic      put_byte;
        t_byte_src byte_src;
        logic      count_byte;
        logic      load_len;
        logic      start;
        logic      round_en;
        t_round    round_idx;
        logic      update;
        logic      reinit;
        t_idx      out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_full;
        logic fill_at_len;
    } t_dp_status;

    function automatic t_word sha1_f(input t_round r, input t_word b,
                                     input t_word c, input t_word d);
        t_word f;
        if (r < t_round'(20)) begin
            f = (b & c) | (~b & d);
        end else if (r < t_round'(40)) begin
            f = b ^ c ^ d;
        end else if (r < t_round'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word sha1_k(input t_round r);
        t_word k;
        if (r < t_round'(20)) begin
            k = 32'h5A827999;
        end else if (r < t_round'(40)) begin
            k = 32'h6ED9EBA1;
        end else if (r < t_round'(60)) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// File: rtl/core/sha1_byte_if.sv
// ----------------------------------------------------------------------------
// sha1_byte_if: message byte channel
// Carries one optional message byte and an end-of-message flag per transfer.
// ----------------------------------------------------------------------------
interface sha1_byte_if;
    import sha1_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  has_byte;
    logic  last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

// File: rtl/core/sha1_digest_if.sv
// ----------------------------------------------------------------------------
// sha1_digest_if: digest word channel
// Carries one 32-bit digest word, its index and a final-word flag.
// ----------------------------------------------------------------------------
interface sha1_digest_if;
    import sha1_pkg::*;

    logic  valid;
    logic  ready;
    t_word digest_word;
    t_idx  word_index;
    logic  last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit: streaming SHA-1 hasher, top level
// A byte that fills the block starts a compression: 80 rounds at one round
// per cycle in the round unit, then one chain add. Bytes are not taken while
// a block is being compressed. End of message: the padding mark and zero
// bytes, one or two compressions, then five digest word transfers. Reset is
// synchronous and active low; it restores the chaining words, clears fill
// and length and holds ready low.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1_byte_if.sink     i_in,
    sha1_digest_if.source o_out
);
    import sha1_pkg::*;

    // The controller sequences everything; the datapath only sees commands.
    // Input is taken only while no block is being compressed, and a finished
    // digest is walked out one word per output transfer before the engine
    // returns to taking bytes for the next message.
    t_dp_cmd    cmd;
    t_dp_status status;

    sha1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_has_byte   (i_in.has_byte),
        .i_last       (i_in.last),
        .i_out_ready  (o_out.ready),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .o_word_index (o_out.word_index),
        .o_last_word  (o_out.last_word)
    );

    // The datapath holds the block window, the working variables and the
    // chaining words; the digest word shown is selected by the word index.
    sha1_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_status      (status),
        .o_digest_word (o_out.digest_word)
    );

    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a digest word is offered");

    // The final word flag marks exactly the fifth word.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_word == (o_out.word_index == LastWord)))
        else $error("last word flag does not match word index");

    // After the final word transfer the engine is ready for the next message.
    a_ready_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> i_in.ready)
        else $error("engine not ready after the digest transfer");

    // A transfer of a non-final word advances the index by one.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_word)
            |=> (o_out.valid && o_out.word_index == $past(o_out.word_index) + 3'd1))
        else $error("digest word index did not advance");
endmodule

// File: rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl: SHA-1 sequencer
// Accepts bytes, steps the padding sequence, counts the 80 rounds of each
// compression and walks the five digest words out.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_has_byte,
    input  logic                 i_last,
    input  logic                 i_out_ready,
    input  sha1_pkg::t_dp_status i_status,
    output sha1_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output sha1_pkg::t_idx       o_word_index,
    output logic                 o_last_word
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_final, n_final;
    t_round r_round, n_round;
    t_idx   r_idx, n_idx;
    logic   r_in_ready, r_out_valid;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_final = r_final;
        n_round = r_round;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.byte_src  = SRC_INPUT;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    if (i_has_byte) begin
                        o_cmd.put_byte   = 1'b1;
                        o_cmd.count_byte = 1'b1;
                    end
                    if (i_has_byte && i_status.fill_full) begin
                        o_cmd.start = 1'b1;
                        n_state = S_ROUND;
                        n_round = '0;
                        n_final = 1'b0;
                        n_ret   = i_last ? S_PAD_MARK : S_IDLE;
                    end else if (i_last) begin
                        n_state = S_PAD_MARK;
                    end
                end
            end
            S_PAD_MARK: begin
                o_cmd.put_byte = 1'b1;
                o_cmd.byte_src = SRC_MARK;
                if (i_status.fill_full) begin
                    o_cmd.start = 1'b1;
                    n_state = S_ROUND;
                    n_round = '0;
                    n_final = 1'b0;
                    n_ret   = S_PAD_ZERO;
                end else begin
                    n_state = S_PAD_ZERO;
                end
            end
            S_PAD_ZERO: begin
                if (i_status.fill_at_len) begin
                    o_cmd.load_len = 1'b1;
                    o_cmd.start    = 1'b1;
                    n_state = S_ROUND;
                    n_round = '0;
                    n_final = 1'b1;
                end else begin
                    o_cmd.put_byte = 1'b1;
                    o_cmd.byte_src = SRC_ZERO;
                    if (i_status.fill_full) begin
                        o_cmd.start = 1'b1;
                        n_state = S_ROUND;
                        n_round = '0;
                        n_final = 1'b0;
                        n_ret   = S_PAD_ZERO;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round == LastRound) begin
                    n_state = S_UPDATE;
                end else begin
                    n_round = r_round + t_round'(1);
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_idx   = '0;
                n_state = r_final ? S_EMIT : r_ret;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (r_idx == LastWord) begin
                        o_cmd.reinit = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_final     <= 1'b0;
            r_round     <= '0;
            r_idx       <= '0;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_final     <= n_final;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_EMIT);
        end
    end

    assign o_in_ready   = r_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LastWord);
endmodule

// File: rtl/core/sha1_datapath.sv
// ----------------------------------------------------------------------------
// sha1_datapath: SHA-1 block buffer, schedule and round unit
// Holds the block as a 16-word window that also shifts out the message
// schedule, the working variables, the chaining words and the length count.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1_pkg::t_dp_cmd    i_cmd,
    input  sha1_pkg::t_byte      i_data_byte,
    output sha1_pkg::t_dp_status o_status,
    output sha1_pkg::t_word      o_digest_word
);
    import sha1_pkg::*;

    t_word       r_h [ChainN];
    t_word       r_w [BlockWords];
    t_word       r_a, r_b, r_c, r_d, r_e;
    t_fill       r_fill;
    logic [63:0] r_bits;

    t_byte      put_val;
    logic [1:0] lane;
    t_word      sched_mix;
    t_word      w_next;
    t_word      round_sum;

    always_comb begin
        unique case (i_cmd.byte_src)
            SRC_INPUT: put_val = i_data_byte;
            SRC_MARK:  put_val = PadMark;
            SRC_ZERO:  put_val = '0;
            default:   put_val = '0;
        endcase
    end

    // Bytes go in big-endian: the first byte of a word lands in its top lane.
    assign lane      = ~r_fill[1:0];
    assign sched_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_next    = {sched_mix[30:0], sched_mix[31]};
    assign round_sum = {r_a[26:0], r_a[31:27]} + sha1_f(i_cmd.round_idx, r_b, r_c, r_d)
                     + r_e + sha1_k(i_cmd.round_idx) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_en) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BlockWords-1] <= w_next;
        end else if (i_cmd.load_len) begin
            r_w[BlockWords-2] <= r_bits[63:32];
            r_w[BlockWords-1] <= r_bits[31:0];
        end else if (i_cmd.put_byte) begin
            r_w[r_fill[5:2]][{lane, 3'b000} +: 8] <= put_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= round_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            for (int i = 0; i < ChainN; i++) begin
                r_h[i] <= ChainInit[i];
            end
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.update) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.put_byte) begin
                r_fill <= r_fill + t_fill'(1);
            end
            if (i_cmd.count_byte) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.out_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = '0;
        endcase
    end

    assign o_status.fill_full   = (r_fill == FullFill);
    assign o_status.fill_at_len = (r_fill == LenFill);
endmodule
